// ===== hw/rtl/ordered_list_manager_core_assert.svh =====
// Assertion macros for the list manager RTL, used by olm_seq.
// Define NO_ASSERTIONS to compile them out.
`ifndef ORDERED_LIST_MANAGER_CORE_ASSERT_SVH
`define ORDERED_LIST_MANAGER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define OLM_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: assertion failed");

`define OLM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define OLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define OLM_ASSERT_ALWAYS(label, clk, rst, cond)

`define OLM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define OLM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/olm_pkg.sv =====
package olm_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_POP,
    S_INS_PLACE,
    S_WALK,
    S_INS_LINK,
    S_INS_SPLICE,
    S_ERA_HEAD,
    S_ERA_NODE,
    S_ERA_UNLINK,
    S_ERA_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    status_t status;
  } res_ctl_t;

endpackage

// ===== hw/rtl/olm_ram.sv =====
module olm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/olm_seq.sv =====
`include "ordered_list_manager_core_assert.svh"

module olm_seq #(
  parameter int CAPACITY   = olm_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = olm_pkg::DEF_DATA_WIDTH,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            op,
  input  logic [CNT_W-1:0]      position,
  input  logic [DATA_WIDTH-1:0] value,
  // link memory
  output logic                  lk_we,
  output logic [IDX_W-1:0]      lk_waddr,
  output logic [IDX_W-1:0]      lk_wdata,
  output logic                  lk_re,
  output logic [IDX_W-1:0]      lk_raddr,
  input  logic [IDX_W-1:0]      lk_rdata,
  // element memory
  output logic                  el_we,
  output logic [IDX_W-1:0]      el_waddr,
  output logic [DATA_WIDTH-1:0] el_wdata,
  output logic                  el_re,
  output logic [IDX_W-1:0]      el_raddr,
  input  logic [DATA_WIDTH-1:0] el_rdata,
  // result buffer
  output olm_pkg::res_ctl_t     res_ctl,
  output logic [DATA_WIDTH-1:0] res_removed,
  output logic [CNT_W-1:0]      res_count,
  input  logic                  res_free
);

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  olm_pkg::state_t state, state_next;

  logic [2:0]            op_q;
  logic [CNT_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [IDX_W-1:0]      head, tail, free_head;
  logic [CNT_W-1:0]      count, fill;
  logic [IDX_W-1:0]      cur, prev, node;
  logic [CNT_W-1:0]      remain;
  logic                  link_fresh;
  logic [DATA_WIDTH-1:0] removed;
  olm_pkg::status_t      status_q;

  logic                  is_ins, is_era, is_clr;
  logic [CNT_W-1:0]      tgt;
  olm_pkg::status_t      dec_status;
  logic                  fill_full;
  logic [IDX_W-1:0]      alloc_node;
  logic [IDX_W-1:0]      cur_sel;

  // Decode the held operation into a target position and a verdict.
  always_comb begin
    is_ins = 1'b0;
    is_era = 1'b0;
    is_clr = 1'b0;
    tgt    = pos_q;
    unique case (op_q)
      olm_pkg::OP_PUSH_FRONT: begin
        is_ins = 1'b1;
        tgt    = '0;
      end
      olm_pkg::OP_PUSH_BACK: begin
        is_ins = 1'b1;
        tgt    = count;
      end
      olm_pkg::OP_INSERT_AT: begin
        is_ins = 1'b1;
      end
      olm_pkg::OP_POP_FRONT: begin
        is_era = 1'b1;
        tgt    = '0;
      end
      olm_pkg::OP_POP_BACK: begin
        is_era = 1'b1;
        tgt    = count - 1'b1;
      end
      olm_pkg::OP_ERASE_AT: begin
        is_era = 1'b1;
      end
      olm_pkg::OP_CLEAR: begin
        is_clr = 1'b1;
      end
      default: ;
    endcase

    if (is_ins) begin
      if (tgt > count) begin
        dec_status = olm_pkg::ST_RANGE;
      end else if (count == CAP_CNT) begin
        dec_status = olm_pkg::ST_FULL;
      end else begin
        dec_status = olm_pkg::ST_DONE;
      end
    end else if (is_era) begin
      if ((count == '0) || (tgt >= count)) begin
        dec_status = olm_pkg::ST_RANGE;
      end else begin
        dec_status = olm_pkg::ST_DONE;
      end
    end else if (is_clr) begin
      dec_status = olm_pkg::ST_DONE;
    end else begin
      dec_status = olm_pkg::ST_RANGE;
    end
  end

  // Fresh nodes come from the fill count; recycled ones from the free chain.
  assign fill_full  = (fill == CAP_CNT);
  assign alloc_node = fill_full ? free_head : fill[IDX_W-1:0];

  // During the walk the address chains straight off the link read data.
  assign cur_sel = link_fresh ? lk_rdata : cur;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      olm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = olm_pkg::S_DECODE;
        end
      end
      olm_pkg::S_DECODE: begin
        if ((dec_status != olm_pkg::ST_DONE) || is_clr) begin
          state_next = olm_pkg::S_RESULT;
        end else if (is_ins) begin
          state_next = fill_full ? olm_pkg::S_FREE_POP : olm_pkg::S_INS_PLACE;
        end else if (tgt == '0) begin
          state_next = olm_pkg::S_ERA_HEAD;
        end else begin
          state_next = olm_pkg::S_WALK;
        end
      end
      olm_pkg::S_FREE_POP: state_next = olm_pkg::S_INS_PLACE;
      olm_pkg::S_INS_PLACE: begin
        if ((tgt == '0) || (tgt == count)) begin
          state_next = olm_pkg::S_RESULT;
        end else begin
          state_next = olm_pkg::S_WALK;
        end
      end
      olm_pkg::S_WALK: begin
        if (remain == '0) begin
          state_next = is_ins ? olm_pkg::S_INS_LINK : olm_pkg::S_ERA_NODE;
        end
      end
      olm_pkg::S_INS_LINK:   state_next = olm_pkg::S_INS_SPLICE;
      olm_pkg::S_INS_SPLICE: state_next = olm_pkg::S_RESULT;
      olm_pkg::S_ERA_HEAD:   state_next = olm_pkg::S_RESULT;
      olm_pkg::S_ERA_NODE:   state_next = olm_pkg::S_ERA_UNLINK;
      olm_pkg::S_ERA_UNLINK: state_next = olm_pkg::S_ERA_FREE;
      olm_pkg::S_ERA_FREE:   state_next = olm_pkg::S_RESULT;
      olm_pkg::S_RESULT: begin
        if (res_free) begin
          state_next = olm_pkg::S_IDLE;
        end
      end
      default: state_next = olm_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory accesses and handshakes
  always_comb begin
    in_stall       = 1'b1;
    lk_we          = 1'b0;
    lk_waddr       = node;
    lk_wdata       = free_head;
    lk_re          = 1'b0;
    lk_raddr       = cur_sel;
    el_we          = 1'b0;
    el_waddr       = alloc_node;
    el_wdata       = val_q;
    el_re          = 1'b0;
    el_raddr       = lk_rdata;
    res_ctl.load   = 1'b0;
    res_ctl.status = status_q;
    unique case (state)
      olm_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      olm_pkg::S_DECODE: begin
        if (dec_status == olm_pkg::ST_DONE) begin
          if (is_ins) begin
            el_we = 1'b1;
            if (fill_full) begin
              lk_re    = 1'b1;
              lk_raddr = free_head;
            end
          end else if (is_era && (tgt == '0)) begin
            lk_re    = 1'b1;
            lk_raddr = head;
            el_re    = 1'b1;
            el_raddr = head;
          end
        end
      end
      olm_pkg::S_INS_PLACE: begin
        if (tgt == '0) begin
          lk_we    = 1'b1;
          lk_wdata = head;
        end else if (tgt == count) begin
          lk_we    = 1'b1;
          lk_waddr = tail;
          lk_wdata = node;
        end
      end
      olm_pkg::S_WALK: begin
        lk_re = 1'b1;
      end
      olm_pkg::S_INS_LINK: begin
        lk_we    = 1'b1;
        lk_wdata = lk_rdata;
      end
      olm_pkg::S_INS_SPLICE: begin
        lk_we    = 1'b1;
        lk_waddr = prev;
        lk_wdata = node;
      end
      olm_pkg::S_ERA_HEAD: begin
        lk_we = 1'b1;
      end
      olm_pkg::S_ERA_NODE: begin
        lk_re    = 1'b1;
        lk_raddr = lk_rdata;
        el_re    = 1'b1;
      end
      olm_pkg::S_ERA_UNLINK: begin
        lk_we    = 1'b1;
        lk_waddr = prev;
        lk_wdata = lk_rdata;
      end
      olm_pkg::S_ERA_FREE: begin
        lk_we = 1'b1;
      end
      olm_pkg::S_RESULT: begin
        res_ctl.load = res_free;
      end
      default: ;
    endcase
  end

  assign res_removed = removed;
  assign res_count   = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= olm_pkg::S_IDLE;
      head       <= '0;
      tail       <= '0;
      free_head  <= '0;
      count      <= '0;
      fill       <= '0;
      link_fresh <= 1'b0;
    end else begin
      state      <= state_next;
      link_fresh <= (state == olm_pkg::S_WALK) && (remain != '0);
      unique case (state)
        olm_pkg::S_IDLE: begin
          if (in_valid) begin
            op_q  <= op;
            pos_q <= position;
            val_q <= value;
          end
        end
        olm_pkg::S_DECODE: begin
          status_q <= dec_status;
          removed  <= '0;
          cur      <= head;
          remain   <= tgt - 1'b1;
          node     <= is_ins ? alloc_node : head;
          if (is_clr) begin
            count <= '0;
            fill  <= '0;
            head  <= '0;
            tail  <= '0;
          end else if (is_ins && (dec_status == olm_pkg::ST_DONE) && !fill_full) begin
            fill <= fill + 1'b1;
          end
        end
        olm_pkg::S_FREE_POP: begin
          free_head <= lk_rdata;
        end
        olm_pkg::S_INS_PLACE: begin
          if (tgt == '0) begin
            head  <= node;
            count <= count + 1'b1;
            if (count == '0) begin
              tail <= node;
            end
          end else if (tgt == count) begin
            tail  <= node;
            count <= count + 1'b1;
          end
        end
        olm_pkg::S_WALK: begin
          cur <= cur_sel;
          if (remain != '0) begin
            remain <= remain - 1'b1;
          end else begin
            prev <= cur_sel;
          end
        end
        olm_pkg::S_INS_SPLICE: begin
          count <= count + 1'b1;
        end
        olm_pkg::S_ERA_HEAD: begin
          head      <= lk_rdata;
          removed   <= el_rdata;
          free_head <= node;
          count     <= count - 1'b1;
        end
        olm_pkg::S_ERA_NODE: begin
          node <= lk_rdata;
        end
        olm_pkg::S_ERA_UNLINK: begin
          removed <= el_rdata;
          if (node == tail) begin
            tail <= prev;
          end
        end
        olm_pkg::S_ERA_FREE: begin
          free_head <= node;
          count     <= count - 1'b1;
        end
        default: ;
      endcase
    end
  end

  `OLM_ASSERT_ALWAYS(a_count_within_fill, clk, rst, count <= fill)
  `OLM_ASSERT_ALWAYS(a_fill_within_capacity, clk, rst, fill <= CAP_CNT)
  `OLM_ASSERT_NEXT(a_accept_decodes, clk, rst, in_valid && !in_stall, state == olm_pkg::S_DECODE)
  `OLM_ASSERT_NEXT(a_walk_counts_down, clk, rst, (state == olm_pkg::S_WALK) && (remain != '0), remain == $past(remain) - 1'b1)

endmodule

// ===== hw/rtl/olm_out_buf.sv =====
module olm_out_buf #(
  parameter int DATA_WIDTH = olm_pkg::DEF_DATA_WIDTH,
  parameter int CNT_W      = $clog2(olm_pkg::DEF_CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  olm_pkg::res_ctl_t     res_ctl,
  input  logic [DATA_WIDTH-1:0] res_removed,
  input  logic [CNT_W-1:0]      res_count,
  output logic                  res_free,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] removed_value,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      entry_count
);

  // The slot frees up in the same cycle its transfer completes.
  assign res_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ctl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ctl.load) begin
      removed_value <= res_removed;
      status        <= res_ctl.status;
      entry_count   <= res_count;
    end
  end

endmodule

// ===== hw/rtl/ordered_list_manager_core.sv =====
// Ordered list of up to CAPACITY values held as a singly linked list in two
// single-port-read memories (values and next links). One operation per input
// transfer, one result per operation. Insert at a middle position, and erase
// at or pop back past the head, walk the links from the head one node per
// cycle; the link memory read port sets that pace. A new operation is
// accepted while the previous result still waits on the output register. No
// clearing pass is needed after reset or clear: unused nodes are handed out
// from a fill count.
module ordered_list_manager_core #(
  parameter int CAPACITY   = olm_pkg::DEF_CAPACITY,
  parameter int DATA_WIDTH = olm_pkg::DEF_DATA_WIDTH,
  localparam int IDX_W = $clog2(CAPACITY),
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            op,
  input  logic [CNT_W-1:0]      position,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] removed_value,
  output logic [1:0]            status,
  output logic [CNT_W-1:0]      entry_count
);

  logic                  lk_we, lk_re;
  logic [IDX_W-1:0]      lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic                  el_we, el_re;
  logic [IDX_W-1:0]      el_waddr, el_raddr;
  logic [DATA_WIDTH-1:0] el_wdata, el_rdata;

  olm_pkg::res_ctl_t     res_ctl;
  logic [DATA_WIDTH-1:0] res_removed;
  logic [CNT_W-1:0]      res_count;
  logic                  res_free;

  olm_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (lk_re),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  olm_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_elem_ram (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .re    (el_re),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  olm_seq #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .position    (position),
    .value       (value),
    .lk_we       (lk_we),
    .lk_waddr    (lk_waddr),
    .lk_wdata    (lk_wdata),
    .lk_re       (lk_re),
    .lk_raddr    (lk_raddr),
    .lk_rdata    (lk_rdata),
    .el_we       (el_we),
    .el_waddr    (el_waddr),
    .el_wdata    (el_wdata),
    .el_re       (el_re),
    .el_raddr    (el_raddr),
    .el_rdata    (el_rdata),
    .res_ctl     (res_ctl),
    .res_removed (res_removed),
    .res_count   (res_count),
    .res_free    (res_free)
  );

  olm_out_buf #(
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .res_ctl       (res_ctl),
    .res_removed   (res_removed),
    .res_count     (res_count),
    .res_free      (res_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .removed_value (removed_value),
    .status        (status),
    .entry_count   (entry_count)
  );

endmodule
